>>> rtl/i2cra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access package
// Shared types and constants for the front end, word queue and bus engine.
// ----------------------------------------------------------------------------
package i2cra_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_BEGW  = 2'd1;
    localparam logic [1:0] OP_BEGR  = 2'd2;
    localparam logic [1:0] OP_LOAD  = 2'd3;

    localparam logic [0:0] CFG_ACK_TIMEOUT = 1'd0;
    localparam logic [0:0] CFG_PHASE_TICKS = 1'd1;

    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [7:0] PHASE_TICKS_RST = 8'd1;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_ADDR = 2'd1;
    localparam logic [1:0] ERR_DATA = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [4:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_enable;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       last_byte;
        logic       busy_res;
        logic       done_res;
        logic [1:0] error_code;
    } out_word_t;

endpackage
`default_nettype wire

>>> rtl/i2c_master_register_access_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master register access unit
// Register-addressed burst read and write master advanced by tick words.
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | in_word (in_word_t)
//   out     | out_valid/out_stall| out_word (out_word_t)
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained unless stalled; each word passes through the
// queue and then the engine result register. The engine executes a word
// whenever the queue holds one and the result register is free or being
// taken. Reset is asynchronous and idles the engine but not its result
// register. Output stalls hold the engine and back up the two-entry queue.
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit #(
    parameter int MAX_BYTES = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  i2cra_pkg::in_word_t   in_word,
    output logic                  out_valid,
    input  wire                   out_stall,
    output i2cra_pkg::out_word_t  out_word,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [0:0]            cfg_index,
    input  wire  [7:0]            cfg_data
);
    import i2cra_pkg::*;

    logic      q_full, q_ne, go, out_valid_reg;
    in_word_t  q_word;
    logic [7:0] ack_timeout_reg, phase_ticks_reg;

    assign in_stall  = q_full;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign go        = q_ne && (!out_valid_reg || !out_stall);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            phase_ticks_reg <= PHASE_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_ACK_TIMEOUT) ack_timeout_reg <= cfg_data;
            else                              phase_ticks_reg <= cfg_data;
        end
    end

    // Output valid tracks the engine result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (go) out_valid_reg <= 1'b1;
        else if (!out_stall) out_valid_reg <= 1'b0;
    end

    i2cra_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_word (in_word),
        .full      (q_full),
        .not_empty (q_ne),
        .pop       (go),
        .pop_word  (q_word)
    );

    i2cra_engine #(.MAX_BYTES(MAX_BYTES)) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .word        (q_word),
        .ack_timeout (ack_timeout_reg),
        .phase_ticks (phase_ticks_reg),
        .result      (out_word)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n) go |=> out_valid)
        else $error("executed word produced no result");
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> q_ne)
        else $error("stall with empty queue");

endmodule
`default_nettype wire

>>> rtl/i2cra_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access word queue
// Small two-entry queue that decouples the front end from the bus engine.
// ----------------------------------------------------------------------------
module i2cra_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  i2cra_pkg::in_word_t push_word,
    output logic                full,
    output logic                not_empty,
    input  wire                 pop,
    output i2cra_pkg::in_word_t pop_word
);
    import i2cra_pkg::*;

    in_word_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_word  = mem_reg[rd_ptr_reg];

    // Storage is written only on a push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
        else $error("queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");

endmodule
`default_nettype wire

>>> rtl/i2cra_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access bus engine
// Executes one queued word per cycle while go is asserted: phase machine, write FIFO, result word.
// ----------------------------------------------------------------------------
module i2cra_engine #(
    parameter int MAX_BYTES = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  go,
    input  i2cra_pkg::in_word_t  word,
    input  wire  [7:0]           ack_timeout,
    input  wire  [7:0]           phase_ticks,
    output i2cra_pkg::out_word_t result
);
    import i2cra_pkg::*;

    localparam int IW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BYTES);

    localparam logic [4:0] PH_IDLE = 5'd0,  PH_S1 = 5'd1,   PH_S2 = 5'd2;
    localparam logic [4:0] PH_TXL = 5'd3,   PH_TXH = 5'd4,  PH_AKL = 5'd5;
    localparam logic [4:0] PH_AKH = 5'd6,   PH_AKW = 5'd7,  PH_RXL = 5'd8;
    localparam logic [4:0] PH_RXH = 5'd9,   PH_MAL = 5'd10, PH_MAH = 5'd11;
    localparam logic [4:0] PH_R1 = 5'd12,   PH_R2 = 5'd13,  PH_R3 = 5'd14;
    localparam logic [4:0] PH_P1 = 5'd15,   PH_P2 = 5'd16,  PH_P3 = 5'd17;

    localparam logic [1:0] K_ADDR_W = 2'd0, K_REG = 2'd1, K_ADDR_R = 2'd2, K_DATA = 2'd3;

    logic [4:0]    ph_reg, ph_next;
    logic [2:0]    bit_reg, bit_next;
    logic [7:0]    sh_reg, sh_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [7:0]    wait_reg, wait_next;
    logic [7:0]    pc_reg, pc_next;
    logic [CW-1:0] fcnt_reg, fcnt_next;
    logic [CW-1:0] fidx_reg, fidx_next;
    logic [6:0]    taddr_reg, taddr_next;
    logic [7:0]    treg_reg, treg_next;
    logic          rd_reg, rd_next;
    logic [1:0]    kind_reg, kind_next;
    logic [1:0]    perr_reg, perr_next;
    logic [7:0]    fifo_mem [MAX_BYTES];
    logic [7:0]    fifo_q;
    out_word_t     res_reg, res_next;

    logic [7:0] pt;
    logic [7:0] pc_inc, w_inc;
    logic       fifo_wr;
    logic [7:0] rx_sh;

    assign result = res_reg;
    assign pt     = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    assign pc_inc = pc_reg + 8'd1;
    assign w_inc  = wait_reg + 8'd1;
    assign fifo_q = fifo_mem[fidx_reg[IW-1:0]];
    assign rx_sh  = {sh_reg[6:0], word.sda_in};

    // Write FIFO storage.
    always_ff @(posedge clk)
    begin
        if (fifo_wr)
        begin
            fifo_mem[fcnt_reg[IW-1:0]] <= word.write_byte;
        end
    end

    // Phase machine and result formation.
    always_comb
    begin
        logic          ack_done, acked;
        ph_next = ph_reg;     bit_next = bit_reg;     sh_next = sh_reg;
        rem_next = rem_reg;   wait_next = wait_reg;   pc_next = pc_reg;
        fcnt_next = fcnt_reg; fidx_next = fidx_reg;   taddr_next = taddr_reg;
        treg_next = treg_reg; rd_next = rd_reg;       kind_next = kind_reg;
        perr_next = perr_reg; fifo_wr = 1'b0;
        ack_done = 1'b0;      acked = 1'b0;
        res_next = '0;

        if (ph_reg == PH_IDLE)
        begin
            if (word.operation == OP_BEGW || word.operation == OP_BEGR)
            begin
                taddr_next = word.device_address;
                treg_next  = word.register_address;
                rem_next   = (int'(word.byte_count) > MAX_BYTES) ? MAXC :
                             CW'(word.byte_count);
                rd_next    = (word.operation == OP_BEGR);
                fidx_next  = '0;
                perr_next  = ERR_NONE;
                pc_next    = 8'd0;
                wait_next  = 8'd0;
                ph_next    = PH_S1;
            end
            else if (word.operation == OP_LOAD && fcnt_reg < MAXC)
            begin
                fifo_wr   = 1'b1;
                fcnt_next = fcnt_reg + 1'b1;
            end
        end
        else if (word.operation == OP_TICK)
        begin
            if (ph_reg == PH_AKW)
            begin
                pc_next = 8'd0;
                if (!word.sda_in)
                begin
                    ack_done = 1'b1;
                    acked    = 1'b1;
                end
                else
                begin
                    wait_next = w_inc;
                    if (w_inc == 8'd0 || w_inc >= ack_timeout) ack_done = 1'b1;
                end
            end
            else
            begin
                pc_next = pc_inc;
                if (pc_inc >= pt || pc_inc == 8'd0)
                begin
                    pc_next = 8'd0;
                    case (ph_reg)
                        PH_S1:  ph_next = PH_S2;
                        PH_S2:
                        begin
                            sh_next = {taddr_reg, 1'b0}; kind_next = K_ADDR_W;
                            bit_next = 3'd0; ph_next = PH_TXL;
                        end
                        PH_TXL: ph_next = PH_TXH;
                        PH_TXH:
                        begin
                            if (bit_reg == 3'd7) ph_next = PH_AKL;
                            else
                            begin
                                bit_next = bit_reg + 3'd1;
                                sh_next  = {sh_reg[6:0], 1'b0};
                                ph_next  = PH_TXL;
                            end
                        end
                        PH_AKL: ph_next = PH_AKH;
                        PH_AKH:
                        begin
                            wait_next = 8'd0; ph_next = PH_AKW;
                        end
                        PH_RXL: ph_next = PH_RXH;
                        PH_RXH:
                        begin
                            sh_next = rx_sh;
                            if (bit_reg == 3'd7)
                            begin
                                res_next.read_byte  = rx_sh;
                                res_next.read_valid = 1'b1;
                                res_next.last_byte  = (rem_reg == CW'(1));
                                if (rem_reg != '0) rem_next = rem_reg - 1'b1;
                                ph_next = PH_MAL;
                            end
                            else
                            begin
                                bit_next = bit_reg + 3'd1; ph_next = PH_RXL;
                            end
                        end
                        PH_MAL: ph_next = PH_MAH;
                        PH_MAH:
                        begin
                            if (rem_reg == '0) ph_next = PH_P1;
                            else
                            begin
                                sh_next = 8'd0; bit_next = 3'd0; ph_next = PH_RXL;
                            end
                        end
                        PH_R1:  ph_next = PH_R2;
                        PH_R2:  ph_next = PH_R3;
                        PH_R3:
                        begin
                            sh_next = {taddr_reg, 1'b1}; kind_next = K_ADDR_R;
                            bit_next = 3'd0; ph_next = PH_TXL;
                        end
                        PH_P1:  ph_next = PH_P2;
                        PH_P2:  ph_next = PH_P3;
                        PH_P3:
                        begin
                            res_next.done_res   = 1'b1;
                            res_next.error_code = perr_reg;
                            perr_next = ERR_NONE;
                            if (!rd_reg) fcnt_next = '0;
                            ph_next = PH_IDLE;
                        end
                        default: ph_next = PH_IDLE;
                    endcase
                end
            end
        end

        // Acknowledge outcome, including the next data byte fetch.
        if (ack_done)
        begin
            logic data_next;
            data_next = 1'b0;
            case (kind_reg)
                K_ADDR_W:
                begin
                    if (acked)
                    begin
                        sh_next = treg_reg; kind_next = K_REG;
                        bit_next = 3'd0; ph_next = PH_TXL;
                    end
                    else
                    begin
                        perr_next = ERR_ADDR; ph_next = PH_P1;
                    end
                end
                K_REG:
                begin
                    if (rd_reg) ph_next = PH_R1;
                    else data_next = 1'b1;
                end
                K_ADDR_R:
                begin
                    if (!acked)
                    begin
                        perr_next = ERR_ADDR; ph_next = PH_P1;
                    end
                    else if (rem_reg == '0) ph_next = PH_P1;
                    else
                    begin
                        sh_next = 8'd0; bit_next = 3'd0; ph_next = PH_RXL;
                    end
                end
                default:
                begin
                    if (acked) data_next = 1'b1;
                    else
                    begin
                        perr_next = ERR_DATA; ph_next = PH_P1;
                    end
                end
            endcase
            if (data_next)
            begin
                if (rem_reg == '0) ph_next = PH_P1;
                else
                begin
                    sh_next   = (fidx_reg < fcnt_reg) ? fifo_q : 8'd0;
                    fidx_next = fidx_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                    kind_next = K_DATA; bit_next = 3'd0; ph_next = PH_TXL;
                end
            end
        end

        // Line levels after this word.
        res_next.scl = 1'b1; res_next.sda_out = 1'b1; res_next.sda_enable = 1'b1;
        case (ph_next)
            PH_S2:  res_next.sda_out = 1'b0;
            PH_TXL:
            begin
                res_next.scl = 1'b0; res_next.sda_out = sh_next[7];
            end
            PH_TXH: res_next.sda_out = sh_next[7];
            PH_AKL, PH_RXL:
            begin
                res_next.scl = 1'b0; res_next.sda_enable = 1'b0;
            end
            PH_AKH, PH_AKW, PH_RXH: res_next.sda_enable = 1'b0;
            PH_MAL:
            begin
                res_next.scl = 1'b0; res_next.sda_out = (rem_next == '0);
            end
            PH_MAH: res_next.sda_out = (rem_next == '0);
            PH_R1:  res_next.scl = 1'b0;
            PH_R3:  res_next.sda_out = 1'b0;
            PH_P1:
            begin
                res_next.scl = 1'b0; res_next.sda_out = 1'b0;
            end
            PH_P2:  res_next.sda_out = 1'b0;
            default: ;
        endcase
        res_next.busy_res = (ph_next != PH_IDLE);
    end

    // State registers; the result register advances only on an executed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE;   bit_reg <= '0;   sh_reg <= '0;    rem_reg <= '0;
            wait_reg <= '0;      pc_reg <= '0;    fcnt_reg <= '0;  fidx_reg <= '0;
            taddr_reg <= '0;     treg_reg <= '0;  rd_reg <= 1'b0;  kind_reg <= '0;
            perr_reg <= ERR_NONE;
        end
        else if (go)
        begin
            ph_reg <= ph_next;   bit_reg <= bit_next;   sh_reg <= sh_next;
            rem_reg <= rem_next; wait_reg <= wait_next; pc_reg <= pc_next;
            fcnt_reg <= fcnt_next; fidx_reg <= fidx_next; taddr_reg <= taddr_next;
            treg_reg <= treg_next; rd_reg <= rd_next;   kind_reg <= kind_next;
            perr_reg <= perr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go) res_reg <= res_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) ph_reg <= PH_P3)
        else $error("bad bus phase");
    assert property (@(posedge clk) disable iff (!rst_n) fcnt_reg <= MAXC)
        else $error("write FIFO count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) rem_reg <= MAXC)
        else $error("byte count overflow");

endmodule
`default_nettype wire
